// ===== rtl/thc_pkg.sv =====
// Package for the tilt-compensated heading pipeline: widths, turn constants,
// register indexes and the CORDIC arctangent table. No dependencies.
package thc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ANGLE_ITER_DEF  = 16;
    localparam int IN_FIELDS       = 6;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Fitted East/North components lie in [-2^20, 2^20-1].
    localparam int VEC_B    = 21;
    localparam int LEN_W    = 21;
    localparam int SQ_W     = 43;
    localparam int REF_W    = 16;
    localparam int DOT_W    = 39;
    localparam int PP_SPLIT = 20;
    localparam int XYP_W    = 61;
    localparam int XY_B     = 31;
    localparam int CX_W     = 34;
    localparam int Z_W      = 26;
    localparam int HEAD_W   = 16;
    localparam int ROUND_SH = 8;

    localparam logic signed [Z_W-1:0]  FULL_TURN = 26'sd11796480;
    localparam logic signed [Z_W-1:0]  HALF_TURN = 26'sd5898240;
    localparam logic signed [Z_W-1:0]  ROUND_ADD = 26'sd128;
    localparam logic [HEAD_W-1:0]      OUT_TURN  = 16'd46080;

    localparam logic signed [CFG_W-1:0] OFFSET_X_RST = -16'sd2737;
    localparam logic signed [CFG_W-1:0] OFFSET_Y_RST = 16'sd318;
    localparam logic signed [CFG_W-1:0] OFFSET_Z_RST = -16'sd681;
    localparam logic signed [CFG_W-1:0] REF_X_RST    = 16'sd16384;
    localparam logic signed [CFG_W-1:0] REF_Y_RST    = 16'sd0;
    localparam logic signed [CFG_W-1:0] REF_Z_RST    = 16'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X = 3'd0,
        CFG_OFFSET_Y = 3'd1,
        CFG_OFFSET_Z = 3'd2,
        CFG_REF_X    = 3'd3,
        CFG_REF_Y    = 3'd4,
        CFG_REF_Z    = 3'd5
    } t_cfg_idx;

    // atan(2^-i) in units of 2^-15 degree, rounded.
    function automatic logic signed [Z_W-1:0] thc_atan(input int i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:  a = 26'sd1474560;
            1:  a = 26'sd870484;
            2:  a = 26'sd459940;
            3:  a = 26'sd233473;
            4:  a = 26'sd117189;
            5:  a = 26'sd58653;
            6:  a = 26'sd29333;
            7:  a = 26'sd14667;
            8:  a = 26'sd7334;
            9:  a = 26'sd3667;
            10: a = 26'sd1833;
            11: a = 26'sd917;
            12: a = 26'sd458;
            13: a = 26'sd229;
            14: a = 26'sd115;
            15: a = 26'sd57;
            16: a = 26'sd29;
            17: a = 26'sd14;
            18: a = 26'sd7;
            19: a = 26'sd4;
            20: a = 26'sd2;
            21: a = 26'sd1;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/tilt_compensated_heading.sv =====
// Tilt-compensated compass heading, fully pipelined.
// Depends on thc_pkg, thc_norm, thc_sqrt_cell and thc_cordic_cell.
//
//  port group   dir  contents
//  i_s_*        in   magnetometer and accelerometer sample item
//  o_m_*        out  heading item, degenerate flag on tuser
//  i_cfg_*      in   register writes: offsets and reference vector
//
// One item is taken every cycle while the pipeline is not halted. It holds
// 21 square-root cells and one CORDIC cell per angle step.
// Reset is synchronous; it clears the valid bits and reloads the config registers.
// The pipeline halts only when its last stage holds an item and the
// output register is full and not being taken.
module tilt_compensated_heading #(
    parameter int SAMPLE_BITS      = thc_pkg::SAMPLE_BITS_DEF,
    parameter int ANGLE_ITERATIONS = thc_pkg::ANGLE_ITER_DEF,
    localparam int IN_TDATA_W = ((thc_pkg::IN_FIELDS * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // mag_x, mag_y, mag_z, acc_x, acc_y, acc_z (lowest bits first)
    input  logic [IN_TDATA_W-1:0]          i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // heading
    output logic [thc_pkg::HEAD_W-1:0]     o_m_tdata,
    // degenerate
    output logic [0:0]                     o_m_tuser,
    input  logic                           i_cfg_we,
    input  logic [thc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [thc_pkg::CFG_W-1:0]      i_cfg_data
);
    import thc_pkg::*;

    localparam int S   = SAMPLE_BITS;
    localparam int MW  = ((S > CFG_W) ? S : CFG_W) + 1;
    localparam int PW  = MW + S;
    localparam int EW  = PW + 1;
    localparam int NPW = S + VEC_B;
    localparam int NW  = NPW + 1;
    localparam int ANG = ANGLE_ITERATIONS;
    localparam int NST = 16 + LEN_W + ANG;
    localparam int HIW = DOT_W - PP_SPLIT;

    typedef struct packed {
        logic signed [DOT_W-1:0] de;
        logic signed [DOT_W-1:0] dn;
        logic                    deg;
    } t_side;

    logic signed [CFG_W-1:0] r_off [3];
    logic signed [CFG_W-1:0] r_ref [3];
    logic [NST-1:0]          r_vld;
    logic                    w_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off[0] <= OFFSET_X_RST;
            r_off[1] <= OFFSET_Y_RST;
            r_off[2] <= OFFSET_Z_RST;
            r_ref[0] <= REF_X_RST;
            r_ref[1] <= REF_Y_RST;
            r_ref[2] <= REF_Z_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OFFSET_X: r_off[0] <= i_cfg_data;
                CFG_OFFSET_Y: r_off[1] <= i_cfg_data;
                CFG_OFFSET_Z: r_off[2] <= i_cfg_data;
                CFG_REF_X:    r_ref[0] <= i_cfg_data;
                CFG_REF_Y:    r_ref[1] <= i_cfg_data;
                CFG_REF_Z:    r_ref[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_out_vld;
    assign w_en       = !r_vld[NST-1] || !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_s_tvalid};
        end
    end

    // East = m x a
    logic signed [MW-1:0]    r1_m [3];
    logic signed [S-1:0]     r1_a [3];
    logic signed [PW-1:0]    r2_p [6];
    logic signed [EW-1:0]    r3_e [3];
    logic signed [VEC_B-1:0] w_ef [3];
    logic signed [S-1:0]     r4_a [3];
    logic signed [S-1:0]     r5_a [3];
    logic signed [S-1:0]     r2_a [3];
    logic signed [S-1:0]     r2_a_q [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_m[k] <= MW'($signed(i_s_tdata[k*S +: S])) - MW'(r_off[k]);
                r1_a[k] <= $signed(i_s_tdata[(k+3)*S +: S]);
            end
            r2_p[0] <= r1_m[1] * r1_a[2];
            r2_p[1] <= r1_m[2] * r1_a[1];
            r2_p[2] <= r1_m[2] * r1_a[0];
            r2_p[3] <= r1_m[0] * r1_a[2];
            r2_p[4] <= r1_m[0] * r1_a[1];
            r2_p[5] <= r1_m[1] * r1_a[0];
            for (int k = 0; k < 3; k++) begin
                r3_e[k] <= EW'(r2_p[2*k]) - EW'(r2_p[2*k+1]);
            end
            r4_a <= r2_a_q;
            r5_a <= r4_a;
        end
    end

    // accelerometer copy aligned with r3_e
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_a   <= r1_a;
            r2_a_q <= r2_a;
        end
    end

    thc_norm #(.W(EW), .OB(VEC_B), .NC(3)) u_norm_e (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (r3_e),
        .o_v   (w_ef)
    );

    // North = a x East
    logic signed [NPW-1:0]   r6_p [6];
    logic signed [VEC_B-1:0] r6_ef [3];
    logic                    r6_ez;
    logic signed [NW-1:0]    r7_n [3];
    logic signed [VEC_B-1:0] r7_ef [3];
    logic                    r7_ez;
    logic signed [VEC_B-1:0] r8_ef [3];
    logic                    r8_ez;
    logic signed [VEC_B-1:0] r9_ef [3];
    logic                    r9_ez;
    logic signed [VEC_B-1:0] w_nf [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_p[0] <= r5_a[1] * w_ef[2];
            r6_p[1] <= r5_a[2] * w_ef[1];
            r6_p[2] <= r5_a[2] * w_ef[0];
            r6_p[3] <= r5_a[0] * w_ef[2];
            r6_p[4] <= r5_a[0] * w_ef[1];
            r6_p[5] <= r5_a[1] * w_ef[0];
            r6_ef   <= w_ef;
            r6_ez   <= (w_ef[0] == '0) && (w_ef[1] == '0) && (w_ef[2] == '0);
            for (int k = 0; k < 3; k++) begin
                r7_n[k] <= NW'(r6_p[2*k]) - NW'(r6_p[2*k+1]);
            end
            r7_ef <= r6_ef;
            r7_ez <= r6_ez;
            r8_ef <= r7_ef;
            r8_ez <= r7_ez;
            r9_ef <= r8_ef;
            r9_ez <= r8_ez;
        end
    end

    thc_norm #(.W(NW), .OB(VEC_B), .NC(3)) u_norm_n (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (r7_n),
        .o_v   (w_nf)
    );

    // dot products with the reference and sums of squares
    logic signed [VEC_B+REF_W-1:0] r10_de [3];
    logic signed [VEC_B+REF_W-1:0] r10_dn [3];
    logic signed [2*VEC_B-1:0]     r10_se [3];
    logic signed [2*VEC_B-1:0]     r10_sn [3];
    logic                          r10_deg;
    logic signed [DOT_W-1:0]       r11_de;
    logic signed [DOT_W-1:0]       r11_dn;
    logic [SQ_W-1:0]               r11_se;
    logic [SQ_W-1:0]               r11_sn;
    logic                          r11_deg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r10_de[k] <= r9_ef[k] * r_ref[k];
                r10_dn[k] <= w_nf[k] * r_ref[k];
                r10_se[k] <= r9_ef[k] * r9_ef[k];
                r10_sn[k] <= w_nf[k] * w_nf[k];
            end
            r10_deg <= r9_ez || ((w_nf[0] == '0) && (w_nf[1] == '0) && (w_nf[2] == '0));
            r11_de  <= DOT_W'(r10_de[0]) + DOT_W'(r10_de[1]) + DOT_W'(r10_de[2]);
            r11_dn  <= DOT_W'(r10_dn[0]) + DOT_W'(r10_dn[1]) + DOT_W'(r10_dn[2]);
            r11_se  <= SQ_W'(SQ_W'(r10_se[0]) + SQ_W'(r10_se[1]) + SQ_W'(r10_se[2]));
            r11_sn  <= SQ_W'(SQ_W'(r10_sn[0]) + SQ_W'(r10_sn[1]) + SQ_W'(r10_sn[2]));
            r11_deg <= r10_deg;
        end
    end

    // square root chains for |E| and |N|
    logic [SQ_W-1:0]  w_rem_e [LEN_W+1];
    logic [LEN_W-1:0] w_res_e [LEN_W+1];
    logic [SQ_W-1:0]  w_rem_n [LEN_W+1];
    logic [LEN_W-1:0] w_res_n [LEN_W+1];
    t_side            r_sq_sb [LEN_W];

    assign w_rem_e[0] = r11_se;
    assign w_res_e[0] = '0;
    assign w_rem_n[0] = r11_sn;
    assign w_res_n[0] = '0;

    for (genvar g = 0; g < LEN_W; g++) begin : g_sqrt
        thc_sqrt_cell #(.K(LEN_W - 1 - g)) u_cell_e (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_rem_e[g]),
            .i_res (w_res_e[g]),
            .o_rem (w_rem_e[g+1]),
            .o_res (w_res_e[g+1])
        );
        thc_sqrt_cell #(.K(LEN_W - 1 - g)) u_cell_n (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_rem_n[g]),
            .i_res (w_res_n[g]),
            .o_rem (w_rem_n[g+1]),
            .o_res (w_res_n[g+1])
        );
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sq_sb[g] <= '{de: r11_de, dn: r11_dn, deg: r11_deg};
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sq_sb[g] <= r_sq_sb[g-1];
                end
            end
        end
    end

    // x = dn*|E|, y = de*|N|, each split into two partial products
    logic signed [PP_SPLIT+LEN_W+1:0] r33_xlo, r33_ylo;
    logic signed [HIW+LEN_W:0]        r33_xhi, r33_yhi;
    logic [1:0]                       r33_flg;
    logic signed [XYP_W-1:0]          r34_xy [2];
    logic [1:0]                       r34_flg;
    logic signed [XY_B-1:0]           w_xyf [2];
    logic [1:0]                       r35_flg;
    logic [1:0]                       r36_flg;
    t_side                            w_sb;

    assign w_sb = r_sq_sb[LEN_W-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r33_xlo <= $signed({1'b0, w_sb.dn[PP_SPLIT-1:0]}) *
                       $signed({1'b0, w_res_e[LEN_W]});
            r33_ylo <= $signed({1'b0, w_sb.de[PP_SPLIT-1:0]}) *
                       $signed({1'b0, w_res_n[LEN_W]});
            r33_xhi <= $signed(w_sb.dn[DOT_W-1:PP_SPLIT]) *
                       $signed({1'b0, w_res_e[LEN_W]});
            r33_yhi <= $signed(w_sb.de[DOT_W-1:PP_SPLIT]) *
                       $signed({1'b0, w_res_n[LEN_W]});
            // bit 1: degenerate, bit 0: heading forced to zero
            r33_flg <= {w_sb.deg, w_sb.deg || ((w_sb.de == '0) && (w_sb.dn == '0))};
            r34_xy[0] <= (XYP_W'(r33_xhi) <<< PP_SPLIT) + XYP_W'(r33_xlo);
            r34_xy[1] <= (XYP_W'(r33_yhi) <<< PP_SPLIT) + XYP_W'(r33_ylo);
            r34_flg   <= r33_flg;
            r35_flg   <= r34_flg;
            r36_flg   <= r35_flg;
        end
    end

    thc_norm #(.W(XYP_W), .OB(XY_B), .NC(2)) u_norm_xy (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (r34_xy),
        .o_v   (w_xyf)
    );

    // fold the left half plane over before the rotations
    logic signed [CX_W-1:0] w_cx [ANG+1];
    logic signed [CX_W-1:0] w_cy [ANG+1];
    logic signed [Z_W-1:0]  w_cz [ANG+1];
    logic signed [CX_W-1:0] r37_x, r37_y;
    logic signed [Z_W-1:0]  r37_z;
    logic [1:0]             r37_flg;
    logic [1:0]             r_cf_flg [ANG];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_xyf[0][XY_B-1]) begin
                r37_x <= -CX_W'(w_xyf[0]);
                r37_y <= -CX_W'(w_xyf[1]);
                r37_z <= HALF_TURN;
            end else begin
                r37_x <= CX_W'(w_xyf[0]);
                r37_y <= CX_W'(w_xyf[1]);
                r37_z <= '0;
            end
            r37_flg <= r36_flg;
        end
    end

    assign w_cx[0] = r37_x;
    assign w_cy[0] = r37_y;
    assign w_cz[0] = r37_z;

    for (genvar g = 0; g < ANG; g++) begin : g_cordic
        thc_cordic_cell #(.I(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_cx[g]),
            .i_y   (w_cy[g]),
            .i_z   (w_cz[g]),
            .o_x   (w_cx[g+1]),
            .o_y   (w_cy[g+1]),
            .o_z   (w_cz[g+1])
        );
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_cf_flg[g] <= r37_flg;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_cf_flg[g] <= r_cf_flg[g-1];
                end
            end
        end
    end

    // wrap into one turn and round to 1/128 degree
    logic signed [Z_W-1:0] w_zw;
    logic signed [Z_W-1:0] w_zr;
    logic [HEAD_W-1:0]     w_head;
    logic [1:0]            w_flg;

    assign w_flg = r_cf_flg[ANG-1];

    always_comb begin
        if (w_cz[ANG][Z_W-1]) begin
            w_zw = w_cz[ANG] + FULL_TURN;
        end else if (w_cz[ANG] >= FULL_TURN) begin
            w_zw = w_cz[ANG] - FULL_TURN;
        end else begin
            w_zw = w_cz[ANG];
        end
        w_zr   = (w_zw + ROUND_ADD) >>> ROUND_SH;
        w_head = HEAD_W'(w_zr);
        if (w_head >= OUT_TURN || w_flg[0]) begin
            w_head = '0;
        end
    end

    logic [HEAD_W-1:0] r_out_head;
    logic              r_out_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en && r_vld[NST-1]) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[NST-1]) begin
            r_out_head <= w_head;
            r_out_deg  <= w_flg[1];
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_head;
    assign o_m_tuser[0] = r_out_deg;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("degenerate item with nonzero heading");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata < OUT_TURN)
        else $error("heading out of range");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-1] && r_out_vld && !i_m_tready |-> !o_s_tready)
        else $error("pipeline advanced into a full output register");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_vld[NST-1]))
        else $error("output valid without a finished item");

endmodule

// ===== rtl/thc_norm.sv =====
// Two-stage vector shrink: finds the smallest common right shift that fits
// every component into OB signed bits, then applies it. Uses thc_pkg.
module thc_norm #(
    parameter int W  = 34,
    parameter int OB = 21,
    parameter int NC = 3
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [W-1:0]  i_v [NC],
    output logic signed [OB-1:0] o_v [NC]
);
    import thc_pkg::*;

    localparam int SW = $clog2(W + 1);

    logic signed [W-1:0]  r_v [NC];
    logic [SW-1:0]        r_s;
    logic signed [OB-1:0] r_o [NC];
    logic [W-2:0]         w_d;
    logic [SW-1:0]        w_n;
    logic [SW-1:0]        n_s;

    // A set bit in w_d marks a place where a component changes from sign
    // bits to significant bits; the highest one gives the needed width.
    always_comb begin
        w_d = '0;
        for (int k = 0; k < NC; k++) begin
            w_d = w_d | (i_v[k][W-1:1] ^ i_v[k][W-2:0]);
        end
        w_n = SW'(1);
        for (int j = 0; j < W - 1; j++) begin
            if (w_d[j]) begin
                w_n = SW'(j + 2);
            end
        end
        n_s = (w_n > SW'(OB)) ? (w_n - SW'(OB)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= i_v;
            r_s <= n_s;
            for (int k = 0; k < NC; k++) begin
                r_o[k] <= OB'(r_v[k] >>> r_s);
            end
        end
    end

    assign o_v = r_o;

endmodule

// ===== rtl/thc_sqrt_cell.sv =====
// One cell of the integer square root chain: decides result bit K.
// Uses thc_pkg for the radicand and result widths.
module thc_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [thc_pkg::SQ_W-1:0]  i_rem,
    input  logic [thc_pkg::LEN_W-1:0] i_res,
    output logic [thc_pkg::SQ_W-1:0]  o_rem,
    output logic [thc_pkg::LEN_W-1:0] o_res
);
    import thc_pkg::*;

    logic [SQ_W-1:0]  r_rem;
    logic [LEN_W-1:0] r_res;
    logic [SQ_W:0]    w_test;

    // The remainder holds n - res^2; setting bit K adds res*2^(K+1) + 4^K.
    assign w_test = ((SQ_W + 1)'(i_res) << (K + 1)) + ((SQ_W + 1)'(1) << (2 * K));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if ({1'b0, i_rem} >= w_test) begin
                r_rem <= SQ_W'({1'b0, i_rem} - w_test);
                r_res <= i_res | (LEN_W'(1) << K);
            end else begin
                r_rem <= i_rem;
                r_res <= i_res;
            end
        end
    end

    assign o_rem = r_rem;
    assign o_res = r_res;

endmodule

// ===== rtl/thc_cordic_cell.sv =====
// One vectoring CORDIC rotation, step I, with its own output register.
// Uses thc_pkg for widths and the arctangent table.
module thc_cordic_cell #(
    parameter int I = 0
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [thc_pkg::CX_W-1:0] i_x,
    input  logic signed [thc_pkg::CX_W-1:0] i_y,
    input  logic signed [thc_pkg::Z_W-1:0]  i_z,
    output logic signed [thc_pkg::CX_W-1:0] o_x,
    output logic signed [thc_pkg::CX_W-1:0] o_y,
    output logic signed [thc_pkg::Z_W-1:0]  o_z
);
    import thc_pkg::*;

    localparam logic signed [Z_W-1:0] ANG = thc_atan(I);

    logic signed [CX_W-1:0] r_x;
    logic signed [CX_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[CX_W-1]) begin
                r_x <= i_x + (i_y >>> I);
                r_y <= i_y - (i_x >>> I);
                r_z <= i_z + ANG;
            end else begin
                r_x <= i_x - (i_y >>> I);
                r_y <= i_y + (i_x >>> I);
                r_z <= i_z - ANG;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
